>>> rtl/core/rre_pkg.sv
// ----------------------------------------------------------------------------
// rre_pkg: shared types and constants of the running RMS estimator
// Holds the sequencer state encoding and the fixed field widths.
// ----------------------------------------------------------------------------
package rre_pkg;

  localparam int unsigned WinW = 16;
  localparam int unsigned RmsW = 16;
  localparam logic [WinW-1:0] WinReset = 16'd4000;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StSquare = 6'b000010,
    StDivide = 6'b000100,
    StRewind = 6'b001000,
    StRoot   = 6'b010000,
    StDone   = 6'b100000
  } state_e;

endpackage

>>> rtl/core/running_rms_estimator_top.sv
// ----------------------------------------------------------------------------
// running_rms_estimator_top: running RMS of a signed sample stream
// Squares each sample into a sum; once a window is full, divides the sum by
// the count, rewinds it to mean * (window - 1), and takes the square root.
// ----------------------------------------------------------------------------
// Sequence: Idle captures the magnitude, Square adds its square to the sum,
//   then Divide, Rewind and Root when averaging happens, and Done loads the
//   result register. A new sample is taken only back in Idle, after Done.
// Done waits while a result is still held; one shared subtract/compare unit,
//   one bit per cycle.
// Reset: count, sum, mean square, RMS and warm flag clear; window is 4000.
module running_rms_estimator_top #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [15:0]             cfg_wdata_i,
  input  logic                    sample_valid_i,
  output logic                    sample_ready_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                    result_valid_o,
  input  logic                    result_ready_i,
  output logic [15:0]             rms_value_o,
  output logic                    warmed_up_o
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned WinW  = rre_pkg::WinW;
  localparam int unsigned RmsW  = rre_pkg::RmsW;
  localparam int unsigned SqW   = 2 * SW - 1;
  localparam int unsigned SumW  = SqW + WinW;
  localparam int unsigned RtW   = SW;
  localparam int unsigned SrcW  = 2 * RtW;
  localparam int unsigned AluW  = (RtW + 2 > WinW + 1) ? RtW + 2 : WinW + 1;
  localparam int unsigned IterW = $clog2(SumW + 1);

  rre_pkg::state_e state_q, state_d;

  logic [WinW-1:0]  win_q;
  logic [WinW-1:0]  count_q;
  logic [WinW-1:0]  cnt_q;
  logic [SumW-1:0]  sum_q;
  logic [SqW-1:0]   mean_q;
  logic [SW-1:0]    mag_q;
  logic [SumW-1:0]  div_q;
  logic [AluW-1:0]  rem_q;
  logic [RtW-1:0]   root_q;
  logic [SrcW-1:0]  src_q;
  logic [IterW-1:0] iter_q;
  logic [RtW-1:0]   rms_q;
  logic             warm_q;
  logic             res_valid_q;
  logic [RmsW-1:0]  res_rms_q;
  logic             res_warm_q;

  // Input magnitude
  logic [SW-1:0] mag_in;
  assign mag_in = sample_i[SW-1] ? (~sample_i + SW'(1)) : sample_i;

  // Effective window and derived values
  logic [WinW-1:0] win_eff, win_m1, cnt_next;
  logic [SumW-1:0] sum_added;
  logic [2*SW-1:0] square;
  assign win_eff   = (win_q == '0) ? WinW'(1) : win_q;
  assign win_m1    = win_eff - WinW'(1);
  assign cnt_next  = count_q + WinW'(1);
  assign square    = mag_q * mag_q;
  assign sum_added = sum_q + SumW'(square);

  logic [SumW-1:0] rewind_prod;
  assign rewind_prod = mean_q * win_m1;

  // Shared subtract/compare unit
  logic [AluW-1:0] alu_a, alu_b, alu_diff;
  logic            alu_ge;
  always_comb begin
    if (state_q == rre_pkg::StRoot) begin
      alu_a = {rem_q[AluW-3:0], src_q[SrcW-1 -: 2]};
      alu_b = AluW'({root_q, 2'b01});
    end else begin
      alu_a = {rem_q[AluW-2:0], div_q[SumW-1]};
      alu_b = AluW'(cnt_q);
    end
    alu_ge   = (alu_a >= alu_b);
    alu_diff = alu_a - alu_b;
  end

  logic [SumW-1:0] div_next;
  assign div_next = {div_q[SumW-2:0], alu_ge};

  logic out_free;
  assign out_free = !res_valid_q || result_ready_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rre_pkg::StIdle:   if (sample_valid_i) state_d = rre_pkg::StSquare;
      rre_pkg::StSquare: state_d = (cnt_next >= win_eff) ? rre_pkg::StDivide
                                                         : rre_pkg::StDone;
      rre_pkg::StDivide: if (iter_q == '0) state_d = rre_pkg::StRewind;
      rre_pkg::StRewind: state_d = rre_pkg::StRoot;
      rre_pkg::StRoot:   if (iter_q == '0) state_d = rre_pkg::StDone;
      rre_pkg::StDone:   if (out_free) state_d = rre_pkg::StIdle;
      default:           state_d = rre_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rre_pkg::StIdle;
      win_q       <= rre_pkg::WinReset;
      count_q     <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      rms_q       <= '0;
      warm_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      // load a new result, else drop the one just transferred
      if ((state_q == rre_pkg::StDone) && out_free) begin
        res_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        rre_pkg::StSquare: begin
          if (cnt_next >= win_eff) begin
            sum_q <= sum_added;
          end else begin
            sum_q   <= sum_added;
            count_q <= cnt_next;
          end
        end
        rre_pkg::StDivide: begin
          if (iter_q == '0) begin
            mean_q <= div_next[SqW-1:0];
          end
        end
        rre_pkg::StRewind: begin
          sum_q   <= rewind_prod;
          count_q <= win_m1;
          warm_q  <= 1'b1;
        end
        rre_pkg::StRoot: begin
          if (iter_q == '0) begin
            rms_q <= {root_q[RtW-2:0], alu_ge};
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rre_pkg::StIdle: begin
        mag_q <= mag_in;
      end
      rre_pkg::StSquare: begin
        cnt_q  <= cnt_next;
        div_q  <= sum_added;
        rem_q  <= '0;
        iter_q <= IterW'(SumW - 1);
      end
      rre_pkg::StDivide: begin
        div_q  <= div_next;
        rem_q  <= alu_ge ? alu_diff : alu_a;
        iter_q <= iter_q - IterW'(1);
      end
      rre_pkg::StRewind: begin
        src_q  <= SrcW'(mean_q);
        rem_q  <= '0;
        root_q <= '0;
        iter_q <= IterW'(RtW - 1);
      end
      rre_pkg::StRoot: begin
        src_q  <= {src_q[SrcW-3:0], 2'b00};
        rem_q  <= alu_ge ? alu_diff : alu_a;
        root_q <= {root_q[RtW-2:0], alu_ge};
        iter_q <= iter_q - IterW'(1);
      end
      rre_pkg::StDone: begin
        if (out_free) begin
          res_rms_q  <= RmsW'(rms_q);
          res_warm_q <= warm_q;
        end
      end
      default: ;
    endcase
  end

  assign sample_ready_o = (state_q == rre_pkg::StIdle);
  assign result_valid_o = res_valid_q;
  assign rms_value_o    = res_rms_q;
  assign warmed_up_o    = res_warm_q;

endmodule

>>> tb/rre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_checker: prediction and comparison for the running RMS estimator
// Watches the configuration port and both channels, keeps its own copy of
// window, count, sum of squares, mean square and warm flag, and compares each
// result transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rre_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [rre_pkg::WinW-1:0] cfg_wdata_i,
  input  logic                     sample_valid_i,
  input  logic                     sample_ready_i,
  input  logic [15:0]              sample_i,
  input  logic                     result_valid_i,
  input  logic                     result_ready_i,
  input  logic [rre_pkg::RmsW-1:0] rms_value_i,
  input  logic                     warmed_up_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  typedef struct packed {
    logic [rre_pkg::RmsW-1:0] rms;
    logic                     warm;
  } rms_result_t;

  rms_result_t       rms_due_q[$];
  rms_result_t       due;
  int unsigned       window;
  int unsigned       sample_count;
  longint unsigned   sum_sq;
  longint unsigned   mean_sq;
  logic              warm;
  int unsigned       errors;

  function automatic logic [rre_pkg::RmsW-1:0] floor_root(input longint unsigned v);
    logic [31:0]     root;
    longint unsigned trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = longint'(root | (32'd1 << b));
      if (trial * trial <= v) root = root | (32'd1 << b);
    end
    return root[rre_pkg::RmsW-1:0];
  endfunction

  // Advance the estimator state by one sample and return the result it reports.
  function automatic rms_result_t advance_rms(input logic [15:0] s);
    int signed       v;
    longint unsigned mag;
    int unsigned     win;
    int unsigned     cnt;
    rms_result_t     r;
    v   = $signed(s);
    mag = (v < 0) ? longint'(-v) : longint'(v);
    sum_sq = sum_sq + mag * mag;
    win = (window == 0) ? 1 : window;
    cnt = sample_count + 1;
    if (cnt >= win) begin
      // divisor is the incremented count, which exceeds the window after it was lowered
      mean_sq      = sum_sq / cnt;
      sample_count = win - 1;
      sum_sq       = mean_sq * (win - 1);
      warm         = 1'b1;
    end else begin
      sample_count = cnt;
    end
    r.rms  = floor_root(mean_sq);
    r.warm = warm;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window       = rre_pkg::WinReset;
      sample_count = 0;
      sum_sq       = 0;
      mean_sq      = 0;
      warm         = 1'b0;
      errors       = 0;
      rms_due_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) window = cfg_wdata_i;
      // check the finished transfer before queueing a new prediction
      if (result_valid_i && result_ready_i) begin
        if (rms_due_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result transfer with nothing outstanding: rms=%0d warm=%0b",
                     $realtime, rms_value_i, warmed_up_i);
        end else begin
          due = rms_due_q.pop_front();
          if (rms_value_i !== due.rms || warmed_up_i !== due.warm) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected rms=%0d warm=%0b, got rms=%0d warm=%0b",
                       $realtime, due.rms, due.warm, rms_value_i, warmed_up_i);
          end
        end
      end
      if (sample_valid_i && sample_ready_i) rms_due_q.push_back(advance_rms(sample_i));
      pending_o    <= rms_due_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the running RMS estimator
// Drives samples and window settings with random idling on both channels:
// a directed opening over field extremes and window corner cases, then random
// phases with mostly short windows. A checker beside the block predicts every
// result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_we_i       = 1'b0;
  logic [rre_pkg::WinW-1:0] cfg_wdata_i    = '0;
  logic                     sample_valid_i = 1'b0;
  logic                     sample_ready_o;
  logic [15:0]              sample_i       = '0;
  logic                     result_valid_o;
  logic                     result_ready_i = 1'b0;
  logic [rre_pkg::RmsW-1:0] rms_value_o;
  logic                     warmed_up_o;
  logic                     calm           = 1'b0;
  int unsigned              fail_count;
  int unsigned              pending;

  always #4 clk_i = ~clk_i;

  running_rms_estimator_top #(
    .SAMPLE_WIDTH (16)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .rms_value_o    (rms_value_o),
    .warmed_up_o    (warmed_up_o)
  );

  rre_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_i (sample_ready_o),
    .sample_i       (sample_i),
    .result_valid_i (result_valid_o),
    .result_ready_i (result_ready_i),
    .rms_value_i    (rms_value_o),
    .warmed_up_i    (warmed_up_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk_i) result_ready_i <= calm || ($urandom_range(99) >= 33);

  task automatic send_sample(input logic [15:0] s);
    int gap;
    gap = (!calm && $urandom_range(99) < 33) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      sample_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    do @(posedge clk_i); while (!sample_ready_o);
  endtask

  // Hold off new samples until every outstanding result has been transferred.
  task automatic drain();
    sample_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [rre_pkg::WinW-1:0] w);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [rre_pkg::WinW-1:0] pick_window();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'($urandom_range(200, 2000));
      default: return 16'($urandom_range(2, 24));
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // before warm-up at the reset window: outputs stay zero
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    send_sample(16'hffff);
    send_sample(16'h0001);
    // window of one: the first sample averages over the count, then each is averaged alone
    set_window(16'd1);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0001);
    send_sample(16'hffff);
    // zero window acts as one
    set_window(16'd0);
    send_sample(16'h8000);
    send_sample(16'h0003);
    // raise the window: counting continues, flag stays set
    set_window(16'hffff);
    send_sample(16'h0064);
    send_sample(16'hff9c);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    // lower the window below the count: next sample averages over the count
    set_window(16'd2);
    send_sample(16'h0010);
    send_sample(16'h0020);
    send_sample(16'hffe0);
    set_window(rre_pkg::WinReset);
    send_sample(16'h1234);

    for (int p = 0; p < 12; p++) begin
      set_window(pick_window());
      calm <= (p == 3);
      for (int i = 0; i < 130; i++) send_sample(pick_sample());
    end
    calm <= 1'b0;

    drain();
    repeat (70) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS running_rms_estimator_top");
    end else begin
      $display("FAIL running_rms_estimator_top");
    end
    $finish;
  end

  initial begin
    #(64'd5_000_000);
    $display("FAIL running_rms_estimator_top");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rre_pkg.sv
rtl/core/running_rms_estimator_top.sv
tb/rre_checker.sv
tb/tb.sv
